// ----- rtl/csv_stream_tokenizer_core_defines.svh -----
// Assertion macros shared by the CSV tokenizer RTL.
`ifndef CSV_STREAM_TOKENIZER_CORE_DEFINES_SVH
`define CSV_STREAM_TOKENIZER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CSVT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("csvt: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CSVT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("csvt: next-cycle check failed");

`endif

// ----- rtl/csvt_pkg.sv -----
// Types and constants shared by the CSV tokenizer modules.
package csvt_pkg;

	localparam logic [7:0] CHAR_QUOTE = 8'h22;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_NUL   = 8'h00;

	localparam int COL_IDX_W = 16;
	localparam int ROW_IDX_W = 32;
	localparam int EXT_W     = 64;

	typedef enum logic [2:0] {
		KIND_CELL  = 3'd0,
		KIND_FIELD = 3'd1,
		KIND_ROW   = 3'd2,
		KIND_DONE  = 3'd3,
		KIND_ERROR = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_CORRUPT = 2'd1,
		ERR_EMPTY   = 2'd2
	} err_t;

	typedef struct packed {
		logic inside_quotes;
		logic quote_run_odd;
		logic separator_seen;
		logic prev_newline;
		logic halted;
	} flags_t;

	typedef struct packed {
		kind_t                  kind;
		logic [7:0]             cell_byte;
		logic [COL_IDX_W-1:0]   column_index;
		logic [ROW_IDX_W-1:0]   row_index;
		err_t                   error_code;
	} result_t;

endpackage

// ----- rtl/csv_stream_tokenizer_core.sv -----
// Streaming CSV tokenizer, top level. Bytes of CSV text enter on the s_axis
// side one per transaction, with s_axis_tuser[0] set on a final transaction
// that marks end of file. Each byte yields at most one m_axis transaction:
// a cell byte (quotes kept raw), a field end at a comma, a row end at a
// newline (an error if the column count differs from the header row), and
// at end of file either done (column and row counts) or an error (corrupt
// or empty file). Carriage returns and zero bytes outside quotes produce
// nothing. After done or an error the block drops all further input until
// reset. Throughput is one byte per clock while the consumer does not stall.
// An accepted byte passes the input register and then the result register,
// with the state update between them. s_axis_tready only falls when both
// registers hold an item and the consumer is stalling.
`include "csv_stream_tokenizer_core_defines.svh"
module csv_stream_tokenizer_core #(
	parameter int COLUMN_BITS = 16,
	parameter int ROW_BITS    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic [0:0]  s_axis_tuser,  // [0] end_of_input
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // [7:0] cell_byte, [23:8] column_index,
	                                   // [55:24] row_index, [57:56] error_code
	output logic [2:0]  m_axis_tuser   // [2:0] kind
);

	// input register
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   eoi_s1;

	// tokenizer state
	csvt_pkg::flags_t       flags_q;
	logic [COLUMN_BITS-1:0] col_q;
	logic [COLUMN_BITS-1:0] exp_q;
	logic [ROW_BITS-1:0]    row_q;

	csvt_pkg::flags_t       flags_d;
	logic [COLUMN_BITS-1:0] col_d;
	logic [COLUMN_BITS-1:0] exp_d;
	logic [ROW_BITS-1:0]    row_d;
	logic                   res_valid;
	csvt_pkg::result_t      res;
	csvt_pkg::result_t      res_q;

	logic                   out_free;
	logic                   advance;
	logic                   in_xfer;
	logic                   terminal_out;

	// s1 item moves on once the result register can take whatever it makes
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= s_axis_tdata;
			eoi_s1  <= s_axis_tuser[0];
		end
	end

	csvt_step #(
		.COLUMN_BITS (COLUMN_BITS),
		.ROW_BITS    (ROW_BITS)
	) u_step (
		.data_byte    (byte_s1),
		.end_of_input (eoi_s1),
		.flags_q      (flags_q),
		.col_q        (col_q),
		.exp_q        (exp_q),
		.row_q        (row_q),
		.flags_d      (flags_d),
		.col_d        (col_d),
		.exp_d        (exp_d),
		.row_d        (row_d),
		.res_valid    (res_valid),
		.res          (res)
	);

	// state commits once per byte, in step with the result register load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			col_q   <= COLUMN_BITS'(1);
			exp_q   <= COLUMN_BITS'(1);
			row_q   <= ROW_BITS'(1);
		end else if (advance) begin
			flags_q <= flags_d;
			col_q   <= col_d;
			exp_q   <= exp_d;
			row_q   <= row_d;
		end
	end

	csvt_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && res_valid),
		.res    (res),
		.tready (m_axis_tready),
		.tvalid (m_axis_tvalid),
		.res_q  (res_q),
		.free   (out_free)
	);

	assign m_axis_tuser = res_q.kind;
	assign m_axis_tdata = {6'b0, res_q.error_code, res_q.row_index,
		res_q.column_index, res_q.cell_byte};

	// done or error currently on the result port
	assign terminal_out = m_axis_tvalid &&
		(m_axis_tuser inside {csvt_pkg::KIND_DONE, csvt_pkg::KIND_ERROR});

	// halt is sticky until reset
	`CSVT_ASSERT_NEXT(a_halt_sticky, flags_q.halted, flags_q.halted)
	// a terminal result on the port means the state has already halted
	`CSVT_ASSERT_NOW(a_terminal_halted, terminal_out, flags_q.halted)
	// quote run parity only lives inside quotes
	`CSVT_ASSERT_NOW(a_odd_inside, flags_q.quote_run_odd, flags_q.inside_quotes)

endmodule

// ----- rtl/csvt_step.sv -----
// Per-byte tokenizer decision: next state and optional result.
module csvt_step #(
	parameter int COLUMN_BITS = 16,
	parameter int ROW_BITS    = 32
) (
	input  logic [7:0]             data_byte,
	input  logic                   end_of_input,
	input  csvt_pkg::flags_t       flags_q,
	input  logic [COLUMN_BITS-1:0] col_q,
	input  logic [COLUMN_BITS-1:0] exp_q,
	input  logic [ROW_BITS-1:0]    row_q,
	output csvt_pkg::flags_t       flags_d,
	output logic [COLUMN_BITS-1:0] col_d,
	output logic [COLUMN_BITS-1:0] exp_d,
	output logic [ROW_BITS-1:0]    row_d,
	output logic                   res_valid,
	output csvt_pkg::result_t      res
);

	logic [COLUMN_BITS-1:0]     col_m1;
	logic [ROW_BITS-1:0]        row_m1;
	logic [ROW_BITS-1:0]        row_dec;
	logic [csvt_pkg::EXT_W-1:0] col_ext;
	logic [csvt_pkg::EXT_W-1:0] row_ext;
	logic [csvt_pkg::EXT_W-1:0] exp_ext;
	logic [csvt_pkg::EXT_W-1:0] rdec_ext;
	logic                       was_nl;
	logic                       col_sat;
	logic                       row_sat;

	assign col_m1   = col_q - COLUMN_BITS'(1);
	assign row_m1   = row_q - ROW_BITS'(1);
	assign row_dec  = (row_q > ROW_BITS'(1)) ? row_m1 : row_q;
	assign col_ext  = csvt_pkg::EXT_W'(col_m1);
	assign row_ext  = csvt_pkg::EXT_W'(row_m1);
	assign exp_ext  = csvt_pkg::EXT_W'(exp_q);
	assign rdec_ext = csvt_pkg::EXT_W'(row_dec);
	assign was_nl   = (data_byte == csvt_pkg::CHAR_LF);
	assign col_sat  = (col_q == {COLUMN_BITS{1'b1}});
	assign row_sat  = (row_q == {ROW_BITS{1'b1}});

	always_comb begin
		flags_d              = flags_q;
		col_d                = col_q;
		exp_d                = exp_q;
		row_d                = row_q;
		res_valid            = 1'b0;
		res.kind             = csvt_pkg::KIND_CELL;
		res.cell_byte        = 8'h00;
		res.column_index     = col_ext[csvt_pkg::COL_IDX_W-1:0];
		res.row_index        = row_ext[csvt_pkg::ROW_IDX_W-1:0];
		res.error_code       = csvt_pkg::ERR_NONE;
		if (!flags_q.halted) begin
			if (end_of_input) begin
				res_valid             = 1'b1;
				flags_d.halted        = 1'b1;
				flags_d.inside_quotes = 1'b0;
				flags_d.quote_run_odd = 1'b0;
				res.kind              = csvt_pkg::KIND_ERROR;
				if (flags_q.inside_quotes && !flags_q.quote_run_odd) begin
					res.error_code = csvt_pkg::ERR_CORRUPT;
				end else if (!flags_q.separator_seen) begin
					res.error_code = csvt_pkg::ERR_EMPTY;
				end else if (!flags_q.prev_newline && (col_q != exp_q)) begin
					res.error_code = csvt_pkg::ERR_CORRUPT;
				end else begin
					res.kind         = csvt_pkg::KIND_DONE;
					res.column_index = exp_ext[csvt_pkg::COL_IDX_W-1:0];
					if (flags_q.prev_newline) begin
						row_d         = row_dec;
						res.row_index = rdec_ext[csvt_pkg::ROW_IDX_W-1:0];
					end else begin
						res.row_index = csvt_pkg::ROW_IDX_W'(csvt_pkg::EXT_W'(row_q));
					end
				end
			end else if (flags_q.inside_quotes && (data_byte == csvt_pkg::CHAR_QUOTE)) begin
				// quote inside quotes: flip run parity, byte kept raw
				flags_d.quote_run_odd = !flags_q.quote_run_odd;
				flags_d.prev_newline  = 1'b0;
				res_valid             = 1'b1;
				res.cell_byte         = data_byte;
			end else if (flags_q.inside_quotes && !flags_q.quote_run_odd) begin
				flags_d.prev_newline = was_nl;
				res_valid            = 1'b1;
				res.cell_byte        = data_byte;
			end else begin
				// outside quotes, or an odd run just closed the quote
				flags_d.inside_quotes = 1'b0;
				flags_d.quote_run_odd = 1'b0;
				flags_d.prev_newline  = was_nl;
				case (data_byte)
					csvt_pkg::CHAR_NUL, csvt_pkg::CHAR_CR: begin
						res_valid = 1'b0;
					end
					csvt_pkg::CHAR_COMMA: begin
						flags_d.separator_seen = 1'b1;
						if (!col_sat) begin
							col_d = col_q + COLUMN_BITS'(1);
						end
						res_valid = 1'b1;
						res.kind  = csvt_pkg::KIND_FIELD;
					end
					csvt_pkg::CHAR_QUOTE: begin
						flags_d.inside_quotes = 1'b1;
						res_valid             = 1'b1;
						res.cell_byte         = data_byte;
					end
					csvt_pkg::CHAR_LF: begin
						flags_d.separator_seen = 1'b1;
						res_valid              = 1'b1;
						if ((row_q != ROW_BITS'(1)) && (col_q != exp_q)) begin
							flags_d.halted = 1'b1;
							res.kind       = csvt_pkg::KIND_ERROR;
							res.error_code = csvt_pkg::ERR_CORRUPT;
						end else begin
							if (row_q == ROW_BITS'(1)) begin
								exp_d = col_q;
							end
							if (!row_sat) begin
								row_d = row_q + ROW_BITS'(1);
							end
							col_d    = COLUMN_BITS'(1);
							res.kind = csvt_pkg::KIND_ROW;
						end
					end
					default: begin
						res_valid     = 1'b1;
						res.cell_byte = data_byte;
					end
				endcase
			end
		end
	end

endmodule

// ----- rtl/csvt_out_reg.sv -----
// Result register with stream handshake towards the consumer.
module csvt_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  csvt_pkg::result_t res,
	input  logic              tready,
	output logic              tvalid,
	output csvt_pkg::result_t res_q,
	output logic              free
);

	logic valid_q;

	assign free   = !valid_q || tready;
	assign tvalid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// ----- bench/csv_stream_tokenizer_core_tb.sv -----
// Self-checking testbench for the streaming CSV tokenizer: directed table, then random CSV text.
`timescale 1ns / 1ps
module csv_stream_tokenizer_core_tb;

	// How a directed row is checked: against the predictor, against a typed token,
	// or as a byte that must produce nothing.
	typedef enum logic [1:0] {
		BY_MODEL,
		TYPED_TOKEN,
		TYPED_SILENT
	} check_mode_t;

	typedef struct packed {
		logic [7:0]        data;
		logic              eoi;
		check_mode_t       mode;
		csvt_pkg::result_t want;
	} probe_t;

	// Shape of the last field of a generated row.
	typedef enum int {
		LAST_ANY,
		LAST_CLOSED_QUOTE,
		LAST_OPEN_QUOTE
	} last_field_t;

	// How the file ends; only one ending per run since the block halts until reset.
	typedef enum int {
		END_AFTER_NEWLINE,
		END_NO_NEWLINE,
		END_ON_QUOTE,
		END_SHORT_ROW,
		END_SHORT_TAIL,
		END_OPEN_QUOTE
	} ending_t;

	localparam csvt_pkg::result_t NO_TOKEN =
		'{csvt_pkg::KIND_CELL, 8'h00, 16'd0, 32'd0, csvt_pkg::ERR_NONE};
	localparam int      N_DIRECTED = 24;
	localparam int      N_COLUMNS  = 3;   // set by the header row of the directed table
	localparam int      PAUSE_AT   = 250; // random byte index where the sender drains
	localparam int      AFTER_HALT = 8;

	// Header row: a NUL CR 0xFF , "<,LF NUL "" CR>" , x"" LF ; row 1: 0x80 CR,,0x7F LF
	localparam probe_t DIRECTED [N_DIRECTED] = '{
		'{8'h61, 1'b0, TYPED_TOKEN,
			'{csvt_pkg::KIND_CELL, 8'h61, 16'd0, 32'd0, csvt_pkg::ERR_NONE}},
		'{8'h00, 1'b0, TYPED_SILENT, NO_TOKEN},
		'{8'h0D, 1'b0, TYPED_SILENT, NO_TOKEN},
		'{8'hFF, 1'b0, TYPED_TOKEN,
			'{csvt_pkg::KIND_CELL, 8'hFF, 16'd0, 32'd0, csvt_pkg::ERR_NONE}},
		'{8'h2C, 1'b0, TYPED_TOKEN,
			'{csvt_pkg::KIND_FIELD, 8'h00, 16'd0, 32'd0, csvt_pkg::ERR_NONE}},
		'{8'h22, 1'b0, BY_MODEL,     NO_TOKEN},
		'{8'h2C, 1'b0, BY_MODEL,     NO_TOKEN},
		'{8'h0A, 1'b0, BY_MODEL,     NO_TOKEN},
		'{8'h00, 1'b0, BY_MODEL,     NO_TOKEN},
		'{8'h22, 1'b0, BY_MODEL,     NO_TOKEN},
		'{8'h22, 1'b0, BY_MODEL,     NO_TOKEN},
		'{8'h0D, 1'b0, BY_MODEL,     NO_TOKEN},
		'{8'h22, 1'b0, BY_MODEL,     NO_TOKEN},
		'{8'h2C, 1'b0, BY_MODEL,     NO_TOKEN},
		'{8'h78, 1'b0, BY_MODEL,     NO_TOKEN},
		'{8'h22, 1'b0, BY_MODEL,     NO_TOKEN},
		'{8'h22, 1'b0, BY_MODEL,     NO_TOKEN},
		'{8'h0A, 1'b0, BY_MODEL,     NO_TOKEN},
		'{8'h80, 1'b0, BY_MODEL,     NO_TOKEN},
		'{8'h0D, 1'b0, BY_MODEL,     NO_TOKEN},
		'{8'h2C, 1'b0, BY_MODEL,     NO_TOKEN},
		'{8'h2C, 1'b0, BY_MODEL,     NO_TOKEN},
		'{8'h7F, 1'b0, BY_MODEL,     NO_TOKEN},
		'{8'h0A, 1'b0, BY_MODEL,     NO_TOKEN}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;  // [7:0] data_byte
	logic [0:0]  s_axis_tuser;  // [0] end_of_input
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;  // [7:0] cell_byte, [23:8] column_index,
	                            // [55:24] row_index, [57:56] error_code
	logic [2:0]  m_axis_tuser;  // [2:0] kind

	// Predictor state, mirroring the tokenizer after reset
	logic                           quoted     = 1'b0;
	logic                           quote_odd  = 1'b0;
	logic                           sep_any    = 1'b0;
	logic                           last_lf    = 1'b0;
	logic                           stopped    = 1'b0;
	logic [csvt_pkg::COL_IDX_W-1:0] col_now    = csvt_pkg::COL_IDX_W'(1);
	logic [csvt_pkg::COL_IDX_W-1:0] col_expect = csvt_pkg::COL_IDX_W'(1);
	logic [csvt_pkg::ROW_IDX_W-1:0] row_now    = csvt_pkg::ROW_IDX_W'(1);

	csvt_pkg::result_t pending_tokens [$];
	logic [8:0]        csv_text [$];      // {end_of_input, data_byte}
	int                bytes_accepted = 0;
	int                tokens_seen    = 0;
	int                mismatches     = 0;
	bit                feeding_done   = 1'b0;
	csvt_pkg::result_t want;

	always #2 clk = ~clk;

	csv_stream_tokenizer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Steps the tokenizer state by one input transaction; returns 1 if a token results.
	function automatic bit predict_token(input logic [7:0] b, input logic eoi,
			output csvt_pkg::result_t tok);
		tok              = NO_TOKEN;
		tok.column_index = col_now - csvt_pkg::COL_IDX_W'(1);
		tok.row_index    = row_now - csvt_pkg::ROW_IDX_W'(1);
		if (stopped)
			return 1'b0;
		if (eoi) begin
			// an odd quote run at end of file just closes the quote
			if (quoted) begin
				if (!quote_odd) begin
					stopped = 1'b1;
					tok.kind = csvt_pkg::KIND_ERROR;
					tok.error_code = csvt_pkg::ERR_CORRUPT;
					return 1'b1;
				end
				quoted = 1'b0;
				quote_odd = 1'b0;
			end
			if (!sep_any) begin
				stopped = 1'b1;
				tok.kind = csvt_pkg::KIND_ERROR;
				tok.error_code = csvt_pkg::ERR_EMPTY;
				return 1'b1;
			end
			if (last_lf) begin
				// trailing empty line is not a row
				if (row_now > csvt_pkg::ROW_IDX_W'(1))
					row_now = row_now - csvt_pkg::ROW_IDX_W'(1);
			end else if (col_now != col_expect) begin
				stopped = 1'b1;
				tok.kind = csvt_pkg::KIND_ERROR;
				tok.error_code = csvt_pkg::ERR_CORRUPT;
				return 1'b1;
			end
			stopped = 1'b1;
			tok.kind = csvt_pkg::KIND_DONE;
			tok.column_index = col_expect;
			tok.row_index = row_now;
			return 1'b1;
		end
		if (quoted) begin
			if (b == csvt_pkg::CHAR_QUOTE) begin
				quote_odd = !quote_odd;
				last_lf = 1'b0;
				tok.cell_byte = b;
				return 1'b1;
			end
			if (!quote_odd) begin
				last_lf = (b == csvt_pkg::CHAR_LF);
				tok.cell_byte = b;
				return 1'b1;
			end
			// odd run then a non-quote: the quote has closed, byte is taken outside
			quoted = 1'b0;
			quote_odd = 1'b0;
		end
		last_lf = (b == csvt_pkg::CHAR_LF);
		case (b)
			csvt_pkg::CHAR_NUL, csvt_pkg::CHAR_CR: return 1'b0;
			csvt_pkg::CHAR_COMMA: begin
				sep_any = 1'b1;
				if (col_now != {csvt_pkg::COL_IDX_W{1'b1}})
					col_now = col_now + csvt_pkg::COL_IDX_W'(1);
				tok.kind = csvt_pkg::KIND_FIELD;
			end
			csvt_pkg::CHAR_QUOTE: begin
				quoted = 1'b1;
				quote_odd = 1'b0;
				tok.cell_byte = b;
			end
			csvt_pkg::CHAR_LF: begin
				sep_any = 1'b1;
				if (row_now == csvt_pkg::ROW_IDX_W'(1))
					col_expect = col_now;
				else if (col_now != col_expect) begin
					stopped = 1'b1;
					tok.kind = csvt_pkg::KIND_ERROR;
					tok.error_code = csvt_pkg::ERR_CORRUPT;
					return 1'b1;
				end
				if (row_now != {csvt_pkg::ROW_IDX_W{1'b1}})
					row_now = row_now + csvt_pkg::ROW_IDX_W'(1);
				col_now = csvt_pkg::COL_IDX_W'(1);
				tok.kind = csvt_pkg::KIND_ROW;
			end
			default: tok.cell_byte = b;
		endcase
		return 1'b1;
	endfunction

	task automatic add_byte(input logic [7:0] b);
		csv_text.push_back({1'b0, b});
	endtask

	// Unquoted field: no comma, quote or newline; the odd CR or NUL is dropped by the block.
	task automatic add_plain_field();
		int         n;
		logic [7:0] b;
		n = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(5);
		repeat (n) begin
			if ($urandom_range(9) == 0)
				b = $urandom_range(1) ? csvt_pkg::CHAR_CR : csvt_pkg::CHAR_NUL;
			else
				do b = 8'($urandom_range(255));
				while (b == csvt_pkg::CHAR_COMMA || b == csvt_pkg::CHAR_QUOTE ||
					b == csvt_pkg::CHAR_LF);
			add_byte(b);
		end
	endtask

	// Quoted field with commas, newlines and doubled quotes inside; optionally left open.
	task automatic add_quoted_field(input bit close);
		int         n;
		logic [7:0] b;
		n = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(5);
		add_byte(csvt_pkg::CHAR_QUOTE);
		repeat (n) begin
			case ($urandom_range(7))
				0: begin
					add_byte(csvt_pkg::CHAR_QUOTE);
					add_byte(csvt_pkg::CHAR_QUOTE);
				end
				1: add_byte(csvt_pkg::CHAR_COMMA);
				2: add_byte(csvt_pkg::CHAR_LF);
				3: add_byte($urandom_range(1) ? csvt_pkg::CHAR_CR : csvt_pkg::CHAR_NUL);
				default: begin
					do b = 8'($urandom_range(255));
					while (b == csvt_pkg::CHAR_QUOTE);
					add_byte(b);
				end
			endcase
		end
		if (close)
			add_byte(csvt_pkg::CHAR_QUOTE);
	endtask

	task automatic add_row(input int fields, input bit newline, input last_field_t last);
		logic [7:0] b;
		for (int i = 0; i < fields; i++) begin
			if (i != 0)
				add_byte(csvt_pkg::CHAR_COMMA);
			if (i == fields - 1 && last == LAST_OPEN_QUOTE)
				add_quoted_field(1'b0);
			else if (i == fields - 1 && last == LAST_CLOSED_QUOTE)
				add_quoted_field(1'b1);
			else if ($urandom_range(2) == 0) begin
				add_quoted_field(1'b1);
				// stray text after a closing quote lands in the same cell
				if ($urandom_range(6) == 0) begin
					do b = 8'($urandom_range(255));
					while (b == csvt_pkg::CHAR_COMMA || b == csvt_pkg::CHAR_QUOTE ||
						b == csvt_pkg::CHAR_LF);
					add_byte(b);
				end
			end else
				add_plain_field();
		end
		if (newline) begin
			if ($urandom_range(3) == 0)
				add_byte(csvt_pkg::CHAR_CR);
			add_byte(csvt_pkg::CHAR_LF);
		end
	endtask

	// One input transaction: random idle, offer, wait for acceptance, then predict.
	task automatic offer(input logic [7:0] data, input logic eoi, input check_mode_t mode,
			input csvt_pkg::result_t typed);
		csvt_pkg::result_t tok;
		bit                makes;
		while (!(bytes_accepted >= 300 && bytes_accepted < 420) && $urandom_range(99) < 24) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tuser  <= eoi;
		do @(posedge clk);
		while (!s_axis_tready);
		bytes_accepted++;
		makes = predict_token(data, eoi, tok);
		if (mode == TYPED_TOKEN)
			pending_tokens.push_back(typed);
		else if (mode == BY_MODEL && makes)
			pending_tokens.push_back(tok);
	endtask

	// Sender: reset, directed table, random CSV body and ending, then bytes after the halt
	initial begin : feed_side
		ending_t ending;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= 8'h00;
		s_axis_tuser  <= 1'b0;
		arst_n        <= 1'b0;

		// Random body: well-formed rows matching the header width
		while (csv_text.size() < 660)
			add_row(N_COLUMNS, 1'b1, LAST_ANY);
		ending = ending_t'($urandom_range(5));
		case (ending)
			END_NO_NEWLINE: add_row(N_COLUMNS, 1'b0, LAST_ANY);
			END_ON_QUOTE:   add_row(N_COLUMNS, 1'b0, LAST_CLOSED_QUOTE);
			END_SHORT_ROW:  add_row(N_COLUMNS - 1, 1'b1, LAST_ANY);
			END_SHORT_TAIL: add_row(1, 1'b0, LAST_ANY);
			END_OPEN_QUOTE: add_row(N_COLUMNS, 1'b0, LAST_OPEN_QUOTE);
			default: ;
		endcase
		csv_text.push_back({1'b1, 8'($urandom_range(255))});
		// the block is halted now; these must be swallowed
		repeat (AFTER_HALT)
			csv_text.push_back(9'($urandom_range(511)));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i])
			offer(DIRECTED[i].data, DIRECTED[i].eoi, DIRECTED[i].mode, DIRECTED[i].want);
		foreach (csv_text[i]) begin
			if (i == PAUSE_AT) begin
				// hold off until every outstanding token has been received
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_tokens.size() != 0)
					@(posedge clk);
			end
			offer(csv_text[i][7:0], csv_text[i][8], BY_MODEL, NO_TOKEN);
		end
		s_axis_tvalid <= 1'b0;
		feeding_done = 1'b1;
	end

	// Receiver: random back-pressure, one long stall to fill the pipe, and a quiet window
	initial begin : drain_side
		int cycles;
		int hold_left;
		bit held;
		cycles    = 0;
		hold_left = 0;
		held      = 1'b0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			cycles++;
			if (!held && tokens_seen >= 80) begin
				held = 1'b1;
				hold_left = 64;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (cycles >= 500 && cycles < 800)
				m_axis_tready <= 1'b1;
			else
				m_axis_tready <= ($urandom_range(99) >= 24);
		end
	end

	// Each accepted output transaction against the oldest expected token
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			tokens_seen++;
			if (pending_tokens.size() == 0) begin
				$error("unexpected token: kind %0d, tdata %0h", m_axis_tuser, m_axis_tdata);
				mismatches++;
			end else begin
				want = pending_tokens.pop_front();
				if (m_axis_tuser !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
					mismatches++;
				end
				if (m_axis_tdata[7:0] !== want.cell_byte) begin
					$error("cell_byte: expected %0h, got %0h", want.cell_byte, m_axis_tdata[7:0]);
					mismatches++;
				end
				if (m_axis_tdata[23:8] !== want.column_index) begin
					$error("column_index: expected %0d, got %0d", want.column_index,
						m_axis_tdata[23:8]);
					mismatches++;
				end
				if (m_axis_tdata[55:24] !== want.row_index) begin
					$error("row_index: expected %0d, got %0d", want.row_index,
						m_axis_tdata[55:24]);
					mismatches++;
				end
				if (m_axis_tdata[57:56] !== want.error_code) begin
					$error("error_code: expected %0d, got %0d", want.error_code,
						m_axis_tdata[57:56]);
					mismatches++;
				end
			end
		end
	end

	// Drain, allow for the latency through both registers and any stray token, then report
	initial begin : wrap_up
		wait (feeding_done);
		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin : watchdog
		#400000;
		$display("Mismatches found");
		$finish;
	end

endmodule
